// ===== hdl/d2f28_pkg.sv =====
`default_nettype none
package d2f28_pkg;
  localparam logic [19:0] MantMax = 20'hFFFFF;
  localparam logic [6:0] ExpBias = 7'd24;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  typedef struct packed {
    logic        is_dec;
    logic [63:0] dbl;
    logic [27:0] code;
  } item_t;
endpackage
`default_nettype wire

// ===== hdl/double_to_float28_codec.sv =====
// A start reaches out_valid through the input register and then the result register.
// Throughput: one transaction per cycle; busy is always low.
// Results show for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the valid flags; payload is not reset.
`default_nettype none
module double_to_float28_codec (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_action,
  input  wire  [63:0] in_double_bits,
  input  wire  [27:0] in_packed_code,
  output logic        out_valid,
  output logic [27:0] out_code_result,
  output logic [63:0] out_double_result
);
  import d2f28_pkg::*;

  logic  in_vld_r;
  item_t in_r;
  logic  out_vld_r;
  logic [27:0] code_r, code_nxt;
  logic [63:0] dbl_r, dbl_nxt;

  assign busy = 1'b0;

  // capture transaction
  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= start;
    if (start) in_r <= '{is_dec: (in_action == ACT_DECODE), dbl: in_double_bits,
                         code: in_packed_code};
  end

  d2f28_conv u_conv (.item(in_r), .code_o(code_nxt), .dbl_o(dbl_nxt));

  // register result
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= in_vld_r;
    if (in_vld_r) begin
      code_r <= code_nxt;
      dbl_r  <= dbl_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_code_result   = code_r;
  assign out_double_result = dbl_r;

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid) else $error("result missing");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_result == '0 || out_double_result == '0))
    else $error("both results nonzero");
  a_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !in_action) |-> ##2 (out_double_result == '0)) else $error("encode dbl");
`endif
endmodule
`default_nettype wire

// ===== hdl/d2f28_conv.sv =====
`default_nettype none
module d2f28_conv (
  input  wire d2f28_pkg::item_t item,
  output logic [27:0]           code_o,
  output logic [63:0]           dbl_o
);
  import d2f28_pkg::*;

  logic        sgn;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic signed [12:0] u, e, ec;
  logic [5:0]  sh;
  logic [53:0] mant, j;
  logic [19:0] jm;
  logic [27:0] enc;
  logic [19:0] m;
  logic [4:0]  p;
  logic [51:0] dfrac;
  logic [10:0] dexp;

  // encode: exponent select, round half up, saturate; zero, Inf, NaN and out-of-range exponents give code 0
  always_comb begin
    sgn  = item.dbl[63];
    bexp = item.dbl[62:52];
    frac = item.dbl[51:0];
    u    = $signed({2'b00, bexp}) - 13'sd1023;
    e    = (frac != '0) ? u + 13'sd1 : u;
    ec   = (e < -13'sd24) ? -13'sd24 : e;
    sh   = 6'(13'sd32 + ec - u);
    mant = {1'b0, 1'b1, frac};
    j    = (mant + (54'd1 << (sh - 6'd1))) >> sh;
    jm   = (j > {34'd0, MantMax}) ? MantMax : j[19:0];
    if (bexp == '0 || bexp == 11'h7FF || e < -13'sd40 || ec >= 13'sd104)
      enc = '0;
    else
      enc = {sgn, 7'(ec) + ExpBias, jm};
  end

  // decode: leading one search over the 20-bit mantissa
  always_comb begin
    m = item.code[19:0];
    p = '0;
    for (int i = 1; i < 20; i++)
      if (m[i]) p = 5'(i);
    dfrac = 52'({32'd0, m} << (6'd52 - {1'b0, p}));
    dexp  = 11'({6'd0, p} + {4'd0, item.code[26:20]} + 11'd979);
  end

  assign code_o = item.is_dec ? '0 : enc;
  assign dbl_o  = !item.is_dec ? '0 :
                  (m == '0) ? {item.code[27], 63'd0} : {item.code[27], dexp, dfrac};
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import d2f28_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [63:0] in_double_bits;
  logic [27:0] in_packed_code;
  logic        out_valid;
  logic [27:0] out_code_result;
  logic [63:0] out_double_result;

  double_to_float28_codec DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_double_bits(in_double_bits),
    .in_packed_code(in_packed_code), .out_valid(out_valid),
    .out_code_result(out_code_result), .out_double_result(out_double_result)
  );

  typedef struct packed {
    logic [27:0] code;
    logic [63:0] dbl;
  } conv_t;

  item_t pending_q[$];
  conv_t conv_q[$];
  int    idle_pct;
  bit    hold_off;
  int    n_err;
  int    n_enc;
  int    n_dec;

  // Encode a binary64 pattern into the 28-bit sign.7.20 code.
  function automatic logic [27:0] to_code(input logic [63:0] x);
    logic [10:0]  bexp;
    logic [51:0]  frac;
    int           u;
    int           e;
    int           sh;
    logic [63:0]  mant;
    logic [63:0]  j;
    bexp = x[62:52];
    frac = x[51:0];
    if (bexp == 11'd0 || bexp == 11'h7FF) return 28'd0;
    u = int'(bexp) - 1023;
    e = (frac != 0) ? u + 1 : u;
    if (e < -40) return 28'd0;
    if (e < -24) e = -24;
    if (e >= 104) return 28'd0;
    mant = {12'd1, frac};
    sh = 32 + e - u;
    j = (mant + (64'd1 << (sh - 1))) >> sh;
    if (j > 64'(MantMax)) j = 64'(MantMax);
    return {x[63], 7'(e + 24), j[19:0]};
  endfunction

  // Expand a 28-bit code into the exact binary64 pattern.
  function automatic logic [63:0] to_double(input logic [27:0] c);
    logic [63:0] m;
    int          p;
    logic [10:0] bexp;
    logic [63:0] frac;
    m = {44'd0, c[19:0]};
    if (m == 0) return {c[27], 63'd0};
    p = 0;
    while (p < 19 && (m >> (p + 1)) != 0) p++;
    bexp = 11'(p + int'(c[26:20]) + 1023 - 44);
    frac = m << (52 - p);
    return {c[27], bexp, frac[51:0]};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Double with chosen unbiased exponent and random sign and fraction.
  function automatic logic [63:0] dbl_at(input int u);
    logic [63:0] r;
    r = rand64();
    if ($urandom_range(0, 3) == 0) r[51:0] = 0;
    else if ($urandom_range(0, 3) == 0) r[51:0] = 52'hFFFFFFFFFFFFF;
    return {r[63], 11'(u + 1023), r[51:0]};
  endfunction

  task automatic push_enc(input logic [63:0] x);
    item_t it;
    it.is_dec = ACT_ENCODE;
    it.dbl = x;
    it.code = 28'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic push_dec(input logic [27:0] c);
    item_t it;
    it.is_dec = ACT_DECODE;
    it.dbl = rand64();
    it.code = c;
    pending_q.push_back(it);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Drive one transaction per accepted start; idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_action <= 1'b0;
      in_double_bits <= 64'd0;
      in_packed_code <= 28'd0;
    end else begin
      if (start && !busy) begin
        conv_t ex;
        ex.code = in_action ? 28'd0 : to_code(in_double_bits);
        ex.dbl = in_action ? to_double(in_packed_code) : 64'd0;
        conv_q.push_back(ex);
        if (in_action) n_dec++;
        else n_enc++;
      end
      if (!(start && busy)) begin
        if (!hold_off && pending_q.size() > 0 &&
            $urandom_range(0, 99) >= idle_pct) begin
          item_t it;
          it = pending_q.pop_front();
          start <= 1'b1;
          in_action <= it.is_dec;
          in_double_bits <= it.dbl;
          in_packed_code <= it.code;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      conv_t ex;
      if (conv_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result code=%h dbl=%h",
                                  out_code_result, out_double_result);
      end else begin
        ex = conv_q.pop_front();
        if (out_code_result !== ex.code || out_double_result !== ex.dbl) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp code=%h dbl=%h got code=%h dbl=%h",
                     ex.code, ex.dbl, out_code_result, out_double_result);
        end
      end
    end
  end

  task automatic fill_directed();
    push_enc(64'd0);
    push_enc(64'h8000000000000000);
    push_enc(64'h000FFFFFFFFFFFFF);
    push_enc(64'h7FF0000000000000);
    push_enc(64'hFFF8000000000001);
    push_enc(64'h3FF0000000000000);
    push_enc(64'hBFF8000000000000);
    push_enc(dbl_at(-42));
    push_enc({1'b0, 11'(-41 + 1023), 52'h0000000000001});
    push_enc(dbl_at(-30));
    push_enc({1'b1, 11'(-25 + 1023), 52'hFFFFFFFFFFFFF});
    push_enc({1'b0, 11'(103 + 1023), 52'd0});
    push_enc({1'b0, 11'(103 + 1023), 52'd1});
    push_enc(64'h3FEFFFFFF8000000);
    push_enc(64'h3FE0000008000000);
    push_enc(64'hFFFFFFFFFFFFFFFF);
    push_dec(28'h0000000);
    push_dec(28'h8000000);
    push_dec(28'h7FFFFFF);
    push_dec(28'hFFFFFFF);
    push_dec(28'h0000001);
    push_dec(28'h8F00001);
    push_dec(28'h1880000);
  endtask

  task automatic fill_random(input int n);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: push_enc(rand64());
        1, 2: push_enc(dbl_at($urandom_range(0, 150) - 45));
        3: push_enc(dbl_at($urandom_range(0, 20) - 42));
        default: push_dec(28'($urandom));
      endcase
    end
  endtask

  // Wait on the falling edge so the driver's updates have settled.
  task automatic drain();
    while (pending_q.size() > 0 || start || conv_q.size() > 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    idle_pct = 0; hold_off = 0; n_err = 0; n_enc = 0; n_dec = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    fill_directed();
    drain();
    // Random phases: no idling, sender idles 55%, then 8%.
    idle_pct = 0;  fill_random(500); drain();
    // Wait until every expected result is in before resuming.
    hold_off = 1;  drain(); hold_off = 0;
    idle_pct = 55; fill_random(450); drain();
    idle_pct = 8;  fill_random(450); drain();
    if (conv_q.size() != 0) begin
      n_err++;
      $display("%0d results never arrived", conv_q.size());
    end
    $display("covered directed edge cases plus 1400 random items: %0d encode, %0d decode",
             n_enc, n_dec);
    $display("across three sender idle rates; errors counted: %0d", n_err);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
